FILE: design/v3alu_pkg.sv
// Shared opcode and status codes and the control word carried down the pipeline.
`timescale 1ns / 1ps
`default_nettype none

package v3alu_pkg;

   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_SUB   = 3'd1;
   localparam logic [2:0] OP_SCALE = 3'd2;
   localparam logic [2:0] OP_CROSS = 3'd3;
   localparam logic [2:0] OP_DIST  = 3'd4;
   localparam logic [2:0] OP_NORM  = 3'd5;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SAT  = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;

   // Control word that travels with every request.
   typedef struct packed {
      logic [2:0] op;
      logic       sat;
      logic [2:0] neg;
   } ctl_type;

endpackage

`default_nettype wire

FILE: design/v3alu_front.sv
// Front pipeline: sums, products, cross terms, saturation and the sum of squares.
`timescale 1ns / 1ps
`default_nettype none

module v3alu_front
   import v3alu_pkg::*;
#(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [2:0]        in_op,
   input  logic [2:0][W-1:0] a_in,
   input  logic [2:0][W-1:0] b_in,
   input  logic [W-1:0]      s_in,
   output logic              out_valid,
   output ctl_type           out_ctl,
   output logic [2:0][W-1:0] out_vec,
   output logic [2*W+1:0]    out_ss
);

   localparam logic [3*W:0] RND_PR = {{(3*W+1-2*F){1'b0}}, {(2*F){1'b1}}};
   localparam logic [2*W:0] RND_X  = {{(2*W+1-F){1'b0}}, {F{1'b1}}};
   localparam logic [W-1:0] MAXV   = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINV   = {1'b1, {(W-1){1'b0}}};

   // Truncate toward zero by 2F bits and clamp; the top bit flags saturation.
   function automatic logic [W:0] clamp_pr(input logic signed [3*W:0] v);
      logic signed [3*W:0] r;
      logic signed [3*W:0] t;
      logic [2*W+1:0]      hi;
      logic                fit;
      r   = v + $signed(v[3*W] ? RND_PR : {(3*W+1){1'b0}});
      t   = r >>> (2*F);
      hi  = t[3*W:W-1];
      fit = (&hi) | (~|hi);
      return {~fit, fit ? t[W-1:0] : (t[3*W] ? MINV : MAXV)};
   endfunction

   function automatic logic [W:0] clamp_x(input logic signed [2*W:0] v);
      logic signed [2*W:0] r;
      logic signed [2*W:0] t;
      logic [W+1:0]        hi;
      logic                fit;
      r   = v + $signed(v[2*W] ? RND_X : {(2*W+1){1'b0}});
      t   = r >>> F;
      hi  = t[2*W:W-1];
      fit = (&hi) | (~|hi);
      return {~fit, fit ? t[W-1:0] : (t[2*W] ? MINV : MAXV)};
   endfunction

   function automatic logic [W:0] clamp_as(input logic signed [W:0] v);
      logic fit;
      fit = (v[W] == v[W-1]);
      return {~fit, fit ? v[W-1:0] : (v[W] ? MINV : MAXV)};
   endfunction

   // Control chain.
   logic       s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [2:0] s1_op_ff, s2_op_ff, s3_op_ff;
   ctl_type    s4_ctl_ff, s4_ctl_in;

   // Stage 1.
   logic signed [W:0]     s1_sum_in [3], s1_sum_ff [3], s1_dif_in [3], s1_dif_ff [3];
   logic signed [2*W-1:0] s1_pa_in [3], s1_pa_ff [3];
   logic signed [2*W-1:0] s1_cp_in [3], s1_cp_ff [3], s1_cq_in [3], s1_cq_ff [3];
   logic [W-1:0]          s1_a_ff [3], s1_b_ff [3];
   // Stage 2.
   logic signed [2*W+1:0] s2_sq_in [3], s2_sq_ff [3];
   logic signed [2*W:0]   s2_plo_in [3], s2_plo_ff [3];
   logic signed [2*W-1:0] s2_phi_in [3], s2_phi_ff [3];
   logic signed [2*W:0]   s2_x_in [3], s2_x_ff [3];
   logic signed [W:0]     s2_as_in [3], s2_as_ff [3];
   logic [W-1:0]          s2_a_ff [3];
   // Stage 3.
   logic [2*W+1:0]        s3_ss_in, s3_ss_ff;
   logic signed [3*W:0]   s3_pr_in [3], s3_pr_ff [3];
   logic signed [2*W:0]   s3_x_ff [3];
   logic signed [W:0]     s3_as_ff [3];
   logic [W-1:0]          s3_a_ff [3];
   // Stage 4.
   logic [W-1:0]          s4_vec_in [3], s4_vec_ff [3];
   logic [2*W+1:0]        s4_ss_ff;
   logic                  lane_sat [3];
   logic                  lane_neg [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_op_ff  <= in_op;
         s2_op_ff  <= s1_op_ff;
         s3_op_ff  <= s2_op_ff;
         s4_ctl_ff <= s4_ctl_in;
         s3_ss_ff  <= s3_ss_in;
         s4_ss_ff  <= s3_ss_ff;
      end
   end

   assign s3_ss_in = {1'b0, s2_sq_ff[0][2*W:0]} + {1'b0, s2_sq_ff[1][2*W:0]}
                   + {1'b0, s2_sq_ff[2][2*W:0]};

   for (genvar i = 0; i < 3; i++) begin : g_lane
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;
      logic signed [W-1:0] a_s, b_s, s_s, aj_s, ak_s, bj_s, bk_s;
      logic signed [W:0]   sq_op;
      logic [W:0]          pr_c, x_c, as_c;

      assign a_s  = $signed(a_in[i]);
      assign b_s  = $signed(b_in[i]);
      assign s_s  = $signed(s_in);
      assign aj_s = $signed(a_in[J]);
      assign ak_s = $signed(a_in[K]);
      assign bj_s = $signed(b_in[J]);
      assign bk_s = $signed(b_in[K]);

      assign s1_sum_in[i] = $signed({a_s[W-1], a_s}) + $signed({b_s[W-1], b_s});
      assign s1_dif_in[i] = $signed({a_s[W-1], a_s}) - $signed({b_s[W-1], b_s});
      assign s1_pa_in[i]  = a_s * s_s;
      assign s1_cp_in[i]  = aj_s * bk_s;
      assign s1_cq_in[i]  = ak_s * bj_s;

      assign sq_op = (s1_op_ff == OP_DIST) ? s1_dif_ff[i]
                                          : $signed({s1_a_ff[i][W-1], s1_a_ff[i]});
      assign s2_sq_in[i]  = sq_op * sq_op;
      assign s2_plo_in[i] = $signed({1'b0, s1_pa_ff[i][W-1:0]}) * $signed(s1_b_ff[i]);
      assign s2_phi_in[i] = $signed(s1_pa_ff[i][2*W-1:W]) * $signed(s1_b_ff[i]);
      assign s2_x_in[i]   = $signed({s1_cp_ff[i][2*W-1], s1_cp_ff[i]})
                          - $signed({s1_cq_ff[i][2*W-1], s1_cq_ff[i]});
      assign s2_as_in[i]  = (s1_op_ff == OP_ADD) ? s1_sum_ff[i] : s1_dif_ff[i];

      assign s3_pr_in[i] = $signed({s2_phi_ff[i][2*W-1], s2_phi_ff[i], {W{1'b0}}})
                         + $signed({{W{s2_plo_ff[i][2*W]}}, s2_plo_ff[i]});

      assign pr_c = clamp_pr(s3_pr_ff[i]);
      assign x_c  = clamp_x(s3_x_ff[i]);
      assign as_c = clamp_as(s3_as_ff[i]);
      assign lane_neg[i] = s3_a_ff[i][W-1];

      always_comb begin
         s4_vec_in[i] = '0;
         lane_sat[i]  = 1'b0;
         unique case (s3_op_ff) inside
            OP_ADD, OP_SUB: begin
               s4_vec_in[i] = as_c[W-1:0];
               lane_sat[i]  = as_c[W];
            end
            OP_SCALE: begin
               s4_vec_in[i] = pr_c[W-1:0];
               lane_sat[i]  = pr_c[W];
            end
            OP_CROSS: begin
               s4_vec_in[i] = x_c[W-1:0];
               lane_sat[i]  = x_c[W];
            end
            OP_NORM: begin
               // Magnitude of A; the sign travels in the control word.
               s4_vec_in[i] = lane_neg[i] ? (~s3_a_ff[i] + W'(1)) : s3_a_ff[i];
            end
            default: begin
            end
         endcase
      end

      always_ff @(posedge clock) begin
         if (en) begin
            s1_sum_ff[i] <= s1_sum_in[i];
            s1_dif_ff[i] <= s1_dif_in[i];
            s1_pa_ff[i]  <= s1_pa_in[i];
            s1_cp_ff[i]  <= s1_cp_in[i];
            s1_cq_ff[i]  <= s1_cq_in[i];
            s1_a_ff[i]   <= a_in[i];
            s1_b_ff[i]   <= b_in[i];
            s2_sq_ff[i]  <= s2_sq_in[i];
            s2_plo_ff[i] <= s2_plo_in[i];
            s2_phi_ff[i] <= s2_phi_in[i];
            s2_x_ff[i]   <= s2_x_in[i];
            s2_as_ff[i]  <= s2_as_in[i];
            s2_a_ff[i]   <= s1_a_ff[i];
            s3_pr_ff[i]  <= s3_pr_in[i];
            s3_x_ff[i]   <= s2_x_ff[i];
            s3_as_ff[i]  <= s2_as_ff[i];
            s3_a_ff[i]   <= s2_a_ff[i];
            s4_vec_ff[i] <= s4_vec_in[i];
         end
      end

      assign out_vec[i] = s4_vec_ff[i];
   end

   always_comb begin
      s4_ctl_in.op  = s3_op_ff;
      s4_ctl_in.sat = lane_sat[0] | lane_sat[1] | lane_sat[2];
      s4_ctl_in.neg = {lane_neg[2], lane_neg[1], lane_neg[0]};
   end

   assign out_valid = s4_valid_ff;
   assign out_ctl   = s4_ctl_ff;
   assign out_ss    = s4_ss_ff;

endmodule

`default_nettype wire

FILE: design/v3alu_sqrt.sv
// Pipelined integer square root, one root bit per stage, with a side tag.
`timescale 1ns / 1ps
`default_nettype none

module v3alu_sqrt #(
   parameter int IW = 66,
   parameter int TW = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [IW-1:0]   in_rad,
   input  logic [TW-1:0]   in_tag,
   output logic            out_valid,
   output logic [IW/2-1:0] out_root,
   output logic [TW-1:0]   out_tag
);

   localparam int RW = IW / 2;

   logic          valid_ff [RW];
   logic [IW-1:0] rem_ff [RW];
   logic [RW-1:0] root_ff [RW];
   logic [TW-1:0] tag_ff [RW];

   for (genvar s = 0; s < RW; s++) begin : g_stage
      localparam int K = RW - 1 - s;
      logic          valid_in;
      logic [IW-1:0] rem_cur, rem_in, trial;
      logic [RW-1:0] root_cur, root_in;
      logic [TW-1:0] tag_cur;
      logic          ge;

      if (s == 0) begin : g_first
         assign valid_in = in_valid;
         assign rem_cur  = in_rad;
         assign root_cur = '0;
         assign tag_cur  = in_tag;
      end else begin : g_next
         assign valid_in = valid_ff[s-1];
         assign rem_cur  = rem_ff[s-1];
         assign root_cur = root_ff[s-1];
         assign tag_cur  = tag_ff[s-1];
      end

      assign trial   = (IW'(root_cur) << (K + 1)) + (IW'(1) << (2 * K));
      assign ge      = (rem_cur >= trial);
      assign rem_in  = ge ? (rem_cur - trial) : rem_cur;
      assign root_in = root_cur | (RW'(ge) << K);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_in;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            tag_ff[s]  <= tag_cur;
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_tag   = tag_ff[RW-1];

endmodule

`default_nettype wire

FILE: design/v3alu_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module v3alu_div #(
   parameter int W  = 32,
   parameter int DW = 33,
   parameter int F  = 16,
   parameter int TW = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [2:0][W-1:0] in_mag,
   input  logic [DW-1:0]     in_div,
   input  logic [TW-1:0]     in_tag,
   output logic              out_valid,
   output logic [2:0][F:0]   out_quo,
   output logic [TW-1:0]     out_tag
);

   // The dividend never exceeds the divisor, so only F+1 quotient bits exist.
   localparam int NS  = F + 1;
   localparam int RMW = ((W > DW) ? W : DW) + 1;

   logic           valid_ff [NS];
   logic [DW-1:0]  div_ff [NS];
   logic [TW-1:0]  tag_ff [NS];
   logic [RMW-1:0] rem_ff [NS][3];
   logic [F:0]     quo_ff [NS][3];

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic          valid_in;
      logic [DW-1:0] div_cur;
      logic [TW-1:0] tag_cur;

      if (s == 0) begin : g_first
         assign valid_in = in_valid;
         assign div_cur  = in_div;
         assign tag_cur  = in_tag;
      end else begin : g_next
         assign valid_in = valid_ff[s-1];
         assign div_cur  = div_ff[s-1];
         assign tag_cur  = tag_ff[s-1];
      end

      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic [RMW-1:0] base, dz, rem_in;
         logic [F:0]     quo_in;
         logic           ge;

         if (s == 0) begin : g_first
            assign base   = RMW'(in_mag[l]);
            assign quo_in = (F+1)'(ge);
         end else begin : g_next
            assign base   = {rem_ff[s-1][l][RMW-2:0], 1'b0};
            assign quo_in = {quo_ff[s-1][l][F-1:0], ge};
         end

         assign dz     = RMW'(div_cur);
         assign ge     = (base >= dz);
         assign rem_in = ge ? (base - dz) : base;

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s][l] <= rem_in;
               quo_ff[s][l] <= quo_in;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_in;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            div_ff[s] <= div_cur;
            tag_ff[s] <= tag_cur;
         end
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_out
      assign out_quo[l] = quo_ff[NS-1][l];
   end

   assign out_valid = valid_ff[NS-1];
   assign out_tag   = tag_ff[NS-1];

endmodule

`default_nettype wire

FILE: design/vector3_alu.sv
// Top level of the fixed-point 3-component vector ALU.
//
//   Channel  Direction  Handshake           Payload
//   req      in         req_valid/stall     opcode, vectors A and B, scale factor
//   rsp      out        rsp_valid/stall     vector R, scalar result, status
//
// A request is taken every cycle while req_stall is low and passes through the front stages,
// the bit-per-stage square root and divider, and the output register before it leaves.
// Every opcode runs through the same stages, so results leave in request order.
// Reset (synchronous, active high) clears the valid bits of every stage and the output.
// A stalled response freezes the whole pipeline in place; req_stall follows rsp_stall
// while a response is held, and nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module vector3_alu
   import v3alu_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [2:0]                   req_opcode,
   input  logic signed [DATA_WIDTH-1:0] req_a_x,
   input  logic signed [DATA_WIDTH-1:0] req_a_y,
   input  logic signed [DATA_WIDTH-1:0] req_a_z,
   input  logic signed [DATA_WIDTH-1:0] req_b_x,
   input  logic signed [DATA_WIDTH-1:0] req_b_y,
   input  logic signed [DATA_WIDTH-1:0] req_b_z,
   input  logic signed [DATA_WIDTH-1:0] req_scale_factor,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_r_x,
   output logic signed [DATA_WIDTH-1:0] rsp_r_y,
   output logic signed [DATA_WIDTH-1:0] rsp_r_z,
   output logic [DATA_WIDTH-2:0]        rsp_scalar_result,
   output logic [1:0]                   rsp_status
);

   localparam int W    = DATA_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int CTW  = $bits(ctl_type);
   localparam int VW   = 3 * W;
   localparam int RTW  = W + 1;
   localparam int CMPW = ((F + 1) > W) ? (F + 1) : W;
   localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

   // The pipeline moves whenever the output register is free or is being emptied.
   logic rsp_valid_ff;
   logic en;
   assign en        = ~(rsp_valid_ff & rsp_stall);
   assign req_stall = ~en;

   // Front stages.
   logic [2:0][W-1:0] req_a, req_b;
   logic              f_valid;
   ctl_type           f_ctl;
   logic [2:0][W-1:0] f_vec;
   logic [2*W+1:0]    f_ss;

   assign req_a = {req_a_z, req_a_y, req_a_x};
   assign req_b = {req_b_z, req_b_y, req_b_x};

   v3alu_front #(.W(W), .F(F)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_op     (req_opcode),
      .a_in      (req_a),
      .b_in      (req_b),
      .s_in      (req_scale_factor),
      .out_valid (f_valid),
      .out_ctl   (f_ctl),
      .out_vec   (f_vec),
      .out_ss    (f_ss)
   );

   // Square root of the sum of squares; the control word and vector ride alongside.
   logic                 q_valid;
   logic [RTW-1:0]       q_root;
   logic [CTW+VW-1:0]    q_tag;
   ctl_type              q_ctl;
   logic [2:0][W-1:0]    q_vec;

   v3alu_sqrt #(.IW(2*W+2), .TW(CTW+VW)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_rad    (f_ss),
      .in_tag    ({f_ctl, f_vec}),
      .out_valid (q_valid),
      .out_root  (q_root),
      .out_tag   (q_tag)
   );

   assign {q_ctl, q_vec} = q_tag;

   // Divide each magnitude of A by |A| for normalisation.
   logic                    d_valid;
   logic [2:0][F:0]         d_quo;
   logic [CTW+RTW+VW-1:0]   d_tag;
   ctl_type                 d_ctl;
   logic [RTW-1:0]          d_root;
   logic [2:0][W-1:0]       d_vec;

   v3alu_div #(.W(W), .DW(RTW), .F(F), .TW(CTW+RTW+VW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (q_valid),
      .in_mag    (q_vec),
      .in_div    (q_root),
      .in_tag    ({q_ctl, q_root, q_vec}),
      .out_valid (d_valid),
      .out_quo   (d_quo),
      .out_tag   (d_tag)
   );

   assign {d_ctl, d_root, d_vec} = d_tag;

   // Sign the normalised components and clamp them to the signed range.
   logic [W-1:0] nrm [3];
   logic         nrm_sat [3];

   for (genvar i = 0; i < 3; i++) begin : g_norm
      logic [CMPW-1:0] qz;
      logic [W-1:0]    lim, mag;

      assign qz         = CMPW'(d_quo[i]);
      assign lim        = d_ctl.neg[i] ? LIM_NEG : LIM_POS;
      assign nrm_sat[i] = (qz > CMPW'(lim));
      assign mag        = nrm_sat[i] ? lim : qz[W-1:0];
      assign nrm[i]     = d_ctl.neg[i] ? (~mag + W'(1)) : mag;
   end

   // The scalar result is the root, clamped to the unsigned range of W-1 bits.
   logic                sc_sat;
   logic [W-2:0]        sc_val;
   assign sc_sat = |d_root[W:W-1];
   assign sc_val = sc_sat ? {(W-1){1'b1}} : d_root[W-2:0];

   // Output register.
   logic [W-1:0]        rsp_r_ff [3];
   logic [W-1:0]        rsp_r_in [3];
   logic [W-2:0]        rsp_sc_ff, rsp_sc_in;
   logic [1:0]          rsp_st_ff, rsp_st_in;

   always_comb begin
      rsp_r_in[0] = '0;
      rsp_r_in[1] = '0;
      rsp_r_in[2] = '0;
      rsp_sc_in   = '0;
      rsp_st_in   = ST_OK;
      unique case (d_ctl.op) inside
         OP_ADD, OP_SUB, OP_SCALE, OP_CROSS: begin
            rsp_r_in[0] = d_vec[0];
            rsp_r_in[1] = d_vec[1];
            rsp_r_in[2] = d_vec[2];
            rsp_st_in   = d_ctl.sat ? ST_SAT : ST_OK;
         end
         OP_DIST: begin
            rsp_sc_in = sc_val;
            rsp_st_in = sc_sat ? ST_SAT : ST_OK;
         end
         OP_NORM: begin
            // A zero vector has no direction: report it and leave everything at zero.
            if (d_root == '0) begin
               rsp_st_in = ST_ZERO;
            end else begin
               rsp_r_in[0] = nrm[0];
               rsp_r_in[1] = nrm[1];
               rsp_r_in[2] = nrm[2];
               rsp_sc_in   = sc_val;
               rsp_st_in   = (sc_sat | nrm_sat[0] | nrm_sat[1] | nrm_sat[2]) ? ST_SAT
                                                                              : ST_OK;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_r_ff[0] <= rsp_r_in[0];
         rsp_r_ff[1] <= rsp_r_in[1];
         rsp_r_ff[2] <= rsp_r_in[2];
         rsp_sc_ff   <= rsp_sc_in;
         rsp_st_ff   <= rsp_st_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_r_x           = rsp_r_ff[0];
   assign rsp_r_y           = rsp_r_ff[1];
   assign rsp_r_z           = rsp_r_ff[2];
   assign rsp_scalar_result = rsp_sc_ff;
   assign rsp_status        = rsp_st_ff;

   // A zero-length normalisation leaves every output field at zero.
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_ZERO) |->
      (rsp_r_x == '0 && rsp_r_y == '0 && rsp_r_z == '0 && rsp_scalar_result == '0))
      else $error("zero-length status with non-zero outputs");

   // A saturation status always comes with at least one field at a clamp value.
   a_sat_clamp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_SAT) |->
      (rsp_r_x == LIM_POS || rsp_r_x == LIM_NEG || rsp_r_y == LIM_POS ||
       rsp_r_y == LIM_NEG || rsp_r_z == LIM_POS || rsp_r_z == LIM_NEG ||
       rsp_scalar_result == {(W-1){1'b1}}))
      else $error("saturation reported without a clamped field");

   // While the response is stalled the inner stages hold their contents.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> ($stable(d_valid) && $stable(q_valid) && $stable(f_valid) &&
               $stable(d_tag) && $stable(d_quo)))
      else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
